FILE: rtl/core/hmws_pkg.sv
// Package for the histogram max-window-sum unit: payload structs, sizes,
// register indexes and saturation limits. No dependencies.
package hmws_pkg;

  localparam int NUM_BINS_MAX = 1024;
  localparam int COUNT_BITS   = 16;
  localparam int ADDR_BITS    = $clog2(NUM_BINS_MAX);
  localparam int BINS_BITS    = 11;
  localparam int SUM_BITS     = COUNT_BITS + ADDR_BITS;
  localparam int VALUE_BITS   = 10;
  localparam int CFG_IDX_BITS = 1;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  localparam logic [CFG_IDX_BITS-1:0] REG_NUM_BINS   = 1'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_WINDOW_LEN = 1'd1;

  localparam logic [BINS_BITS-1:0] NUM_BINS_RST   = 11'd1024;
  localparam logic [BINS_BITS-1:0] WINDOW_LEN_RST = 11'd1;

  typedef struct packed {
    logic [VALUE_BITS-1:0] sample_value;
    logic                  last_sample;
  } in_item_t;

  typedef struct packed {
    logic [COUNT_BITS-1:0] max_window_count;
    logic                  range_error;
  } out_item_t;

endpackage

FILE: rtl/core/histogram_max_window_sum_unit.sv
// Histogram max-window-sum unit; depends on hmws_pkg for payload types and sizes.
// A count is written in the cycle after its transfer; the result is valid after the
//   drain, the scan and the compare stage, once the prior result is gone.
// Throughput: one sample per cycle while counting; after the last sample input stalls
//   through the drain, the num_bins-bin scan and a 1024-entry clear sweep (one write port).
// Reset: synchronous, active low; num_bins 1024, window 1, then the clear sweep runs.
module histogram_max_window_sum_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  hmws_pkg::in_item_t                   in_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output hmws_pkg::out_item_t                  out_data,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [hmws_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [hmws_pkg::BINS_BITS-1:0]       cfg_data
);

  localparam int AW = hmws_pkg::ADDR_BITS;
  localparam int BW = hmws_pkg::BINS_BITS;
  localparam int CW = hmws_pkg::COUNT_BITS;
  localparam int SW = hmws_pkg::SUM_BITS;

  // ST_CLEAR: zero sweep over the whole memory (after reset and each result)
  // ST_HIST : counting samples, one transfer per cycle
  // ST_DRAIN: last increment lands in memory; wait for previous result to go
  // ST_SCAN : one bin per cycle, leading and trailing edge of the window
  typedef enum logic [1:0] {ST_CLEAR, ST_HIST, ST_DRAIN, ST_SCAN} state_t;

  state_t          state_r;
  logic [BW-1:0]   num_bins_r, window_len_r;
  logic [AW-1:0]   clr_idx_r, scan_idx_r;
  logic [BW-1:0]   n_r, w_r;
  logic            bad_r, err_r;

  // increment stage and forwarding of the previous write
  logic            s1_v_r, wb_v_r;
  logic [AW-1:0]   s1_addr_r, wb_addr_r;
  logic [CW-1:0]   wb_data_r;

  // scan pipeline: data stage then compare stage
  logic            sc_v_r, sc_trail_r, sc_upd_r, sc_last_r;
  logic            cm_v_r, cm_upd_r, cm_last_r;
  logic [SW-1:0]   sum_r, best_r;

  logic            out_valid_r;
  hmws_pkg::out_item_t out_data_r;

  // memory
  logic [CW-1:0]   bins_mem [hmws_pkg::NUM_BINS_MAX];
  logic [CW-1:0]   rd_a_q, rd_b_q;
  logic            mem_we;
  logic [AW-1:0]   mem_wa, mem_ra, mem_rb;
  logic [CW-1:0]   mem_wd;

  // combinational
  logic [BW-1:0]   bins_eff, win_eff, v_ext, i_ext;
  logic            in_xfer, out_xfer, sample_ok;
  logic [AW-1:0]   sample_addr;
  logic [CW-1:0]   base, inc;
  logic            scan_end, scan_trail, scan_upd;
  logic [SW-1:0]   best_fin;

  assign in_ready  = (state_r == ST_HIST);
  assign in_xfer   = in_valid && in_ready;
  assign out_xfer  = out_valid_r && out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign cfg_ready = 1'b1;

  // Effective bin count and window: zero reads as one, clamp to the memory
  // depth and the window to the bin count.
  always_comb begin
    if (num_bins_r == '0) begin
      bins_eff = BW'(1);
    end else if (num_bins_r > BW'(hmws_pkg::NUM_BINS_MAX)) begin
      bins_eff = BW'(hmws_pkg::NUM_BINS_MAX);
    end else begin
      bins_eff = num_bins_r;
    end
    if (window_len_r == '0) begin
      win_eff = BW'(1);
    end else if (window_len_r > bins_eff) begin
      win_eff = bins_eff;
    end else begin
      win_eff = window_len_r;
    end
  end

  assign v_ext       = BW'(in_data.sample_value);
  assign sample_ok   = (v_ext != '0) && (v_ext <= bins_eff);
  assign sample_addr = AW'(v_ext - BW'(1));

  // Read-before-write memory: a write at the same edge as a read is missed,
  // so the previous write is forwarded.
  assign base = (wb_v_r && (wb_addr_r == s1_addr_r)) ? wb_data_r : rd_a_q;
  assign inc  = (base == hmws_pkg::COUNT_MAX) ? base : base + CW'(1);

  assign i_ext      = BW'(scan_idx_r);
  assign scan_end   = (i_ext == n_r - BW'(1));
  assign scan_trail = (i_ext >= w_r);
  assign scan_upd   = (i_ext >= w_r - BW'(1));

  assign best_fin = (cm_upd_r && (sum_r > best_r)) ? sum_r : best_r;

  always_comb begin
    mem_ra = (state_r == ST_SCAN) ? scan_idx_r : sample_addr;
    mem_rb = AW'(i_ext - w_r);
    if (state_r == ST_CLEAR) begin
      mem_we = 1'b1;
      mem_wa = clr_idx_r;
      mem_wd = '0;
    end else begin
      mem_we = s1_v_r;
      mem_wa = s1_addr_r;
      mem_wd = inc;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      bins_mem[mem_wa] <= mem_wd;
    end
    rd_a_q <= bins_mem[mem_ra];
    rd_b_q <= bins_mem[mem_rb];
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      num_bins_r   <= hmws_pkg::NUM_BINS_RST;
      window_len_r <= hmws_pkg::WINDOW_LEN_RST;
      clr_idx_r    <= '0;
      scan_idx_r   <= '0;
      bad_r        <= 1'b0;
      s1_v_r       <= 1'b0;
      wb_v_r       <= 1'b0;
      sc_v_r       <= 1'b0;
      cm_v_r       <= 1'b0;
      cm_last_r    <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          hmws_pkg::REG_NUM_BINS:   num_bins_r   <= cfg_data;
          hmws_pkg::REG_WINDOW_LEN: window_len_r <= cfg_data;
          default: ;
        endcase
      end

      s1_v_r <= in_xfer && sample_ok;
      wb_v_r <= s1_v_r;
      sc_v_r <= (state_r == ST_SCAN);
      cm_v_r <= sc_v_r;
      cm_last_r <= sc_v_r && sc_last_r;

      if (in_xfer) begin
        if (in_data.last_sample) begin
          bad_r <= 1'b0;
        end else if (!sample_ok) begin
          bad_r <= 1'b1;
        end
      end

      if (cm_last_r) begin
        out_valid_r <= 1'b1;
      end else if (out_xfer) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        ST_CLEAR: begin
          // index wraps to zero on the last entry
          clr_idx_r <= clr_idx_r + AW'(1);
          if (clr_idx_r == AW'(hmws_pkg::NUM_BINS_MAX - 1)) begin
            state_r <= ST_HIST;
          end
        end
        ST_HIST: begin
          if (in_xfer && in_data.last_sample) begin
            state_r <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          scan_idx_r <= '0;
          if (!out_valid_r) begin
            state_r <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          scan_idx_r <= scan_idx_r + AW'(1);
          if (scan_end) begin
            state_r <= ST_CLEAR;
          end
        end
        default: state_r <= ST_CLEAR;
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    s1_addr_r <= sample_addr;
    wb_addr_r <= s1_addr_r;
    wb_data_r <= inc;

    if (in_xfer && in_data.last_sample) begin
      n_r   <= bins_eff;
      w_r   <= win_eff;
      err_r <= bad_r || !sample_ok;
    end

    sc_trail_r <= scan_trail;
    sc_upd_r   <= scan_upd;
    sc_last_r  <= scan_end;
    cm_upd_r   <= sc_upd_r;

    // running window sum and best so far
    if (state_r == ST_DRAIN) begin
      sum_r  <= '0;
      best_r <= '0;
    end else begin
      if (sc_v_r) begin
        sum_r <= sum_r + SW'(rd_a_q) - (sc_trail_r ? SW'(rd_b_q) : SW'(0));
      end
      if (cm_v_r) begin
        best_r <= best_fin;
      end
    end

    if (cm_last_r) begin
      out_data_r.max_window_count <= (best_fin > SW'(hmws_pkg::COUNT_MAX)) ?
                                     hmws_pkg::COUNT_MAX : CW'(best_fin);
      out_data_r.range_error      <= err_r;
    end
  end

endmodule

FILE: tb/tb_histogram_max_window_sum_unit.sv
`timescale 1ns / 1ps
// Self-checking testbench for histogram_max_window_sum_unit: streams sample sets,
// predicts each peak window count and range flag, and scoreboards the results.
// Depends on hmws_pkg and the unit's RTL only.
module tb_histogram_max_window_sum_unit;

  localparam int NUM_BINS_MAX    = hmws_pkg::NUM_BINS_MAX;
  localparam int COUNT_BITS      = hmws_pkg::COUNT_BITS;
  localparam int VALUE_BITS      = hmws_pkg::VALUE_BITS;
  localparam int BINS_BITS       = hmws_pkg::BINS_BITS;
  localparam int CFG_IDX_BITS    = hmws_pkg::CFG_IDX_BITS;

  localparam int LIMIT_CYCLES    = 12_000_000;
  localparam int SETTLE_CYCLES   = NUM_BINS_MAX + 16;   // scan tail + clear sweep
  localparam int DRAIN_CYCLES    = NUM_BINS_MAX + 64;
  localparam int RANDOM_ITEMS    = 1400;
  localparam int SUB_PHASE_ITEMS = 50;
  localparam int VALUE_MAX       = (1 << VALUE_BITS) - 1;
  localparam int CFG_MAX         = (1 << BINS_BITS) - 1;

  logic                    clk       = 1'b0;
  logic                    rst_n     = 1'b0;
  logic                    in_valid  = 1'b0;
  logic                    in_ready;
  hmws_pkg::in_item_t      in_data   = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  hmws_pkg::out_item_t     out_data;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [BINS_BITS-1:0]    cfg_data  = '0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  histogram_max_window_sum_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // Prediction state: our own histogram, bad-value flag and register shadows.
  // ---------------------------------------------------------------------------
  logic [COUNT_BITS-1:0] hist_bins [NUM_BINS_MAX] = '{default: '0};
  logic                  set_has_bad    = 1'b0;
  logic [BINS_BITS-1:0]  num_bins_reg   = hmws_pkg::NUM_BINS_RST;
  logic [BINS_BITS-1:0]  window_len_reg = hmws_pkg::WINDOW_LEN_RST;

  hmws_pkg::in_item_t  sample_queue [$];   // samples waiting to be driven
  hmws_pkg::out_item_t peak_queue   [$];   // predicted results, oldest first

  int idle_in_pct   = 31;
  int idle_out_pct  = 54;
  int error_count   = 0;
  int samples_done  = 0;
  int sets_done     = 0;
  int bad_sets      = 0;
  int reg_writes    = 0;
  int cycle_count   = 0;
  int items_queued  = 0;

  // num_bins as the unit applies it: 0 acts as 1, anything past the
  // histogram depth acts as the full depth.
  function automatic int eff_bins();
    int n;
    n = int'(num_bins_reg);
    if (n < 1) n = 1;
    if (n > NUM_BINS_MAX) n = NUM_BINS_MAX;
    return n;
  endfunction

  // Count one accepted sample; on the set's last sample run the sliding
  // window over the live bins, queue the expected result and clear.
  function automatic void tally_sample(hmws_pkg::in_item_t s);
    int                  v;
    int                  n;
    int                  w;
    longint              sum;
    longint              best;
    hmws_pkg::out_item_t r;
    v = int'(s.sample_value);
    n = eff_bins();
    if (v >= 1 && v <= n) begin
      if (hist_bins[v-1] != hmws_pkg::COUNT_MAX) hist_bins[v-1]++;
    end else begin
      set_has_bad = 1'b1;
    end
    samples_done++;
    if (s.last_sample) begin
      w = int'(window_len_reg);
      if (w < 1) w = 1;
      if (w > n) w = n;
      sum = 0;
      for (int i = 0; i < w; i++) sum += hist_bins[i];
      best = sum;
      // sums are exact; only the reported peak saturates
      for (int i = w; i < n; i++) begin
        sum = sum + hist_bins[i] - hist_bins[i-w];
        if (sum > best) best = sum;
      end
      r.max_window_count = (best > longint'(hmws_pkg::COUNT_MAX)) ?
                           hmws_pkg::COUNT_MAX : best[COUNT_BITS-1:0];
      r.range_error      = set_has_bad;
      peak_queue.push_back(r);
      sets_done++;
      if (set_has_bad) bad_sets++;
      // the whole store is cleared, bins above num_bins included
      foreach (hist_bins[i]) hist_bins[i] = '0;
      set_has_bad = 1'b0;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Sample driver: drives sample_queue in order, inserts random gaps, keeps valid and
  // payload stable while a transfer is stalled. Prediction runs on transfer.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        tally_sample(in_data);
        void'(sample_queue.pop_front());
      end
      if (!(in_valid && !in_ready)) begin
        if (sample_queue.size() != 0 && $urandom_range(0, 99) >= idle_in_pct) begin
          in_valid <= 1'b1;
          in_data  <= sample_queue[0];
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor: random backpressure, compares each transfer with the
  // oldest prediction field by field.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    hmws_pkg::out_item_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= idle_out_pct);
      if (out_valid && out_ready) begin
        if (peak_queue.size() == 0) begin
          error_count++;
          $display("%0t: result with none expected: max_window_count %0d range_error %0b",
                   $time, out_data.max_window_count, out_data.range_error);
        end else begin
          want = peak_queue.pop_front();
          if (out_data.max_window_count !== want.max_window_count) begin
            error_count++;
            $display("%0t: max_window_count expected %0d actual %0d", $time,
                     want.max_window_count, out_data.max_window_count);
          end
          if (out_data.range_error !== want.range_error) begin
            error_count++;
            $display("%0t: range_error expected %0b actual %0b", $time,
                     want.range_error, out_data.range_error);
          end
        end
      end
    end
  end

  // Watchdog: a hang anywhere ends the run as a failure.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("%0t: timeout, %0d results still expected", $time, peak_queue.size());
      $display("tb_histogram_max_window_sum_unit NOT OK");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic push_sample(int v, bit last);
    hmws_pkg::in_item_t s;
    s.sample_value = VALUE_BITS'(v);
    s.last_sample  = last;
    sample_queue.push_back(s);
    items_queued++;
  endtask

  // Idle means: nothing queued or in flight, no result outstanding, and the
  // scan and clear sweep behind the last result given time to finish.
  task automatic wait_for_idle();
    while (sample_queue.size() != 0 || in_valid || peak_queue.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [BINS_BITS-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == hmws_pkg::REG_NUM_BINS) num_bins_reg = val;
    else                               window_len_reg = val;
    reg_writes++;
  endtask

  task automatic apply_setting(int nb, int wl);
    wait_for_idle();
    write_reg(hmws_pkg::REG_NUM_BINS, BINS_BITS'(nb));
    write_reg(hmws_pkg::REG_WINDOW_LEN, BINS_BITS'(wl));
    @(negedge clk);
  endtask

  // Register settings lean on the edges: zero, one, full depth, past the
  // field's useful range, and windows at or beyond the bin count.
  task automatic pick_setting();
    int nb;
    int n;
    int wl;
    case ($urandom_range(0, 5))
      0:       nb = 0;
      1:       nb = 1;
      2:       nb = CFG_MAX;
      3:       nb = NUM_BINS_MAX;
      4:       nb = $urandom_range(2, 40);
      default: nb = $urandom_range(41, NUM_BINS_MAX);
    endcase
    n = (nb < 1) ? 1 : (nb > NUM_BINS_MAX) ? NUM_BINS_MAX : nb;
    case ($urandom_range(0, 7))
      0:       wl = 0;
      1:       wl = 1;
      2:       wl = n;
      3:       wl = n + $urandom_range(1, 50);
      4:       wl = CFG_MAX;
      default: wl = $urandom_range(1, n);
    endcase
    apply_setting(nb, wl);
  endtask

  // Queue whole sets of at least n_items samples. Half the values cluster around
  // a per-set center so windows see real peaks; the rest spread over the range or
  // probe its edges and out-of-range values. With leave_open the final set gets no
  // last marker and runs on into the next register setting.
  task automatic queue_sets(int n_items, bit leave_open);
    int made;
    int len;
    int r;
    int n;
    int top;
    int center;
    int spread;
    int v;
    made = 0;
    n    = eff_bins();
    top  = (n > VALUE_MAX) ? VALUE_MAX : n;
    while (made < n_items) begin
      r   = $urandom_range(0, 99);
      len = (r < 70) ? $urandom_range(1, 8) :
            (r < 95) ? $urandom_range(9, 40) : $urandom_range(41, 120);
      center = $urandom_range(1, top);
      spread = $urandom_range(0, 8);
      for (int i = 0; i < len; i++) begin
        r = $urandom_range(0, 99);
        if (r < 6)       v = 0;
        else if (r < 12) v = $urandom_range(0, VALUE_MAX);
        else if (r < 16) v = top;
        else if (r < 19) v = (n < VALUE_MAX) ? n + 1 : VALUE_MAX;
        else if (r < 50) v = $urandom_range(1, top);
        else begin
          v = center + $urandom_range(0, spread);
          if (v > top) v = top;
        end
        push_sample(v, (i == len - 1) && !(leave_open && made + len >= n_items));
      end
      made += len;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: reset settings, value extremes, zero and out-of-range values.
    push_sample(1, 0);
    push_sample(VALUE_MAX, 0);
    push_sample(0, 0);
    push_sample(5, 0);
    push_sample(5, 1);
    push_sample(7, 1);              // one-sample set
    // zero registers act as one bin, one-wide window
    apply_setting(0, 0);
    push_sample(1, 0);
    push_sample(2, 0);
    push_sample(1, 1);
    // all-ones registers: full depth, window clamped to the whole histogram
    apply_setting(CFG_MAX, CFG_MAX);
    push_sample(VALUE_MAX, 0);
    push_sample(512, 0);
    push_sample(1, 1);
    // small histogram, then shrink it while a set is still open
    apply_setting(8, 3);
    push_sample(8, 0);
    push_sample(8, 0);
    push_sample(9, 0);
    push_sample(6, 0);
    push_sample(7, 0);
    push_sample(1, 1);
    push_sample(3, 0);
    push_sample(4, 0);
    apply_setting(4, 5);            // 8 is now out of range, window clamps to 4
    push_sample(8, 0);
    push_sample(4, 0);
    push_sample(4, 1);

    // Random: three backpressure profiles sharing the item budget, register
    // settings changed between sub-phases, sometimes with a set left open.
    for (int p = 0; p < 3; p++) begin
      idle_in_pct  = (p == 0) ? 31 : (p == 1) ? 54 : 0;
      idle_out_pct = (p == 0) ? 54 : (p == 1) ? 31 : 0;
      while (items_queued < (p + 1) * RANDOM_ITEMS / 3) begin
        pick_setting();
        queue_sets(SUB_PHASE_ITEMS, $urandom_range(0, 3) == 0);
      end
    end

    wait_for_idle();
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Covered %0d samples in %0d sets (%0d flagged out of range), %0d register writes,",
             samples_done, sets_done, bad_sets, reg_writes);
    $display("with edge register settings, three stall profiles and sets open across changes.");
    if (error_count == 0 && peak_queue.size() == 0) begin
      $display("tb_histogram_max_window_sum_unit OK");
    end else begin
      $display("tb_histogram_max_window_sum_unit NOT OK");
    end
    $finish;
  end

endmodule
